// ===== hw/rtl/bwn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwn_pkg
// Shared types and constants for the number-to-words block.
// ----------------------------------------------------------------------------
package bwn_pkg;

   localparam int NUM_W      = 31;
   localparam int TOK_W      = 5;
   localparam int DIGITS     = 10;
   // Two input bits are folded into the decimal digits per conversion step.
   localparam int STEPS      = (NUM_W + 1) / 2;
   localparam int STEP_CNT_W = $clog2(STEPS);
   localparam int QUEUE_DEPTH = 2;

   typedef logic [3:0]              digit_type;
   typedef digit_type [DIGITS-1:0]  bcd_type;
   typedef logic [TOK_W-1:0]        token_type;

   localparam token_type TOK_ZERO     = 5'd0;
   localparam token_type TOK_TEN      = 5'd10;
   localparam token_type TOK_TENS_OFS = 5'd18;
   localparam token_type TOK_HUNDRED  = 5'd28;
   localparam token_type TOK_THOUSAND = 5'd29;
   localparam token_type TOK_MILLION  = 5'd30;
   localparam token_type TOK_BILLION  = 5'd31;

endpackage

// ===== hw/rtl/binary_to_english_number_words.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_english_number_words
// Spells a 31-bit unsigned number as a stream of English word tokens.
// ----------------------------------------------------------------------------
// Each accepted number produces between one and sixteen word tokens, one per
// accepted response word, with rsp_last_word set on the final token. Tokens
// are 0 zero, 1-9 one..nine, 10-19 ten..nineteen, 20-27 twenty..ninety,
// 28 hundred, 29 thousand, 30 million and 31 billion; zero reads as the single
// token zero, and an all-zero group emits nothing, scale word included. The
// front end converts a number to decimal two bits per cycle, then hands the
// digits to a two-entry queue; it takes a new number only once it has handed
// off the last one, and it waits while the queue is full. The back end emits
// one token per cycle while rsp_stall is low. Sustained throughput is set by
// the slower of the two. Both ends run concurrently, and the registered
// response stage keeps the input side moving while a token waits on rsp_stall.
// ----------------------------------------------------------------------------
module binary_to_english_number_words import bwn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [NUM_W-1:0] req_number_value,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output token_type        rsp_word_token,
   output logic             rsp_last_word
);

   logic    q_push, q_full, q_pop, q_valid;
   bcd_type conv_digits, head_digits;

   // Front end: decimal conversion.
   bwn_conv u_conv (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_number_value (req_number_value),
      .q_push           (q_push),
      .q_full           (q_full),
      .q_digits         (conv_digits)
   );

   // Decouples conversion from word emission.
   bwn_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (conv_digits),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_data  (head_digits)
   );

   // Back end: token sequencing and output register.
   bwn_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_digits       (head_digits),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_word_token (rsp_word_token),
      .rsp_last_word  (rsp_last_word)
   );

endmodule

// ===== hw/rtl/bwn_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwn_conv
// Front end: accepts a number and converts it to ten decimal digits by
// shift-and-add-three, two bits per cycle, then hands the digits to the queue.
// ----------------------------------------------------------------------------
module bwn_conv import bwn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [NUM_W-1:0] req_number_value,
   output logic             q_push,
   input  logic             q_full,
   output bcd_type          q_digits
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_RUN  = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [STEP_CNT_W-1:0]  cnt_ff, cnt_in;
   bcd_type                bcd_ff, bcd_in;
   logic [2*STEPS-1:0]     bin_ff, bin_in;
   logic                   accept;

   // One bit of shift-and-add-three: correct each digit, then shift in a bit.
   function automatic bcd_type dd_bit(bcd_type b, logic din);
      bcd_type c;
      c = b;
      for (int i = 0; i < DIGITS; i++) begin
         if (c[i] >= 4'd5) begin
            c[i] = c[i] + 4'd3;
         end
      end
      return bcd_type'({c, din});
   endfunction

   assign q_push    = (state_ff == S_DONE) && !q_full;
   assign req_stall = (state_ff == S_RUN) || ((state_ff == S_DONE) && q_full);
   assign accept    = req_valid && !req_stall;
   assign q_digits  = bcd_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bcd_in   = bcd_ff;
      bin_in   = bin_ff;
      unique case (state_ff)
         S_IDLE: begin
            state_in = S_IDLE;
         end
         S_RUN: begin
            bcd_in = dd_bit(dd_bit(bcd_ff, bin_ff[2*STEPS-1]), bin_ff[2*STEPS-2]);
            bin_in = {bin_ff[2*STEPS-3:0], 2'b00};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == STEP_CNT_W'(STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (q_push) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (accept) begin
         state_in = S_RUN;
         cnt_in   = '0;
         bcd_in   = '0;
         bin_in   = (2*STEPS)'(req_number_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

endmodule

// ===== hw/rtl/bwn_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwn_fifo
// Short queue of converted digit sets between the front and back ends.
// ----------------------------------------------------------------------------
module bwn_fifo import bwn_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  bcd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output bcd_type head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   bcd_type               mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]        count_ff, count_in;

   assign full       = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/bwn_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bwn_emit
// Back end: turns one set of decimal digits into its word tokens, one per
// cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module bwn_emit import bwn_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  bcd_type   q_digits,
   output logic      q_pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output token_type rsp_word_token,
   output logic      rsp_last_word
);

   // Four groups (billions, millions, thousands, units) of five word slots:
   // hundreds digit, hundred, tens or teen, ones, scale. One extra slot for
   // the lone word zero.
   localparam int GROUPS = 4;
   localparam int GSLOTS = 5;
   localparam int SLOTS  = GROUPS * GSLOTS + 1;

   typedef token_type [SLOTS-1:0] slot_tok_type;

   function automatic logic [SLOTS-1:0] slot_mask(bcd_type d);
      logic [SLOTS-1:0] m;
      digit_type h, t, u;
      m = '0;
      for (int g = 0; g < GROUPS; g++) begin
         if (g == 0) begin
            h = '0;
            t = '0;
            u = d[DIGITS-1];
         end else begin
            h = d[11 - 3*g];
            t = d[10 - 3*g];
            u = d[9 - 3*g];
         end
         m[g*GSLOTS + 0] = (h != '0);
         m[g*GSLOTS + 1] = (h != '0);
         m[g*GSLOTS + 2] = (t != '0);
         m[g*GSLOTS + 3] = (u != '0) && (t != 4'd1);
         m[g*GSLOTS + 4] = ((h | t | u) != '0) && (g != GROUPS - 1);
      end
      m[SLOTS-1] = (d == '0);
      return m;
   endfunction

   function automatic slot_tok_type slot_tokens(bcd_type d);
      slot_tok_type s;
      digit_type h, t, u;
      for (int g = 0; g < GROUPS; g++) begin
         if (g == 0) begin
            h = '0;
            t = '0;
            u = d[DIGITS-1];
         end else begin
            h = d[11 - 3*g];
            t = d[10 - 3*g];
            u = d[9 - 3*g];
         end
         s[g*GSLOTS + 0] = {1'b0, h};
         s[g*GSLOTS + 1] = TOK_HUNDRED;
         s[g*GSLOTS + 2] = (t == 4'd1) ? TOK_TEN + {1'b0, u} : TOK_TENS_OFS + {1'b0, t};
         s[g*GSLOTS + 3] = {1'b0, u};
         case (g)
            0:       s[g*GSLOTS + 4] = TOK_BILLION;
            1:       s[g*GSLOTS + 4] = TOK_MILLION;
            2:       s[g*GSLOTS + 4] = TOK_THOUSAND;
            default: s[g*GSLOTS + 4] = TOK_ZERO;
         endcase
      end
      s[SLOTS-1] = TOK_ZERO;
      return s;
   endfunction

   bcd_type          digits_ff, digits_in;
   logic [SLOTS-1:0] rem_ff, rem_in;
   logic             out_valid_ff, out_valid_in;
   token_type        tok_ff, tok_in;
   logic             last_ff, last_in;

   logic [SLOTS-1:0] pick, rem_after;
   slot_tok_type     toks;
   token_type        tok_sel;
   logic             adv, have, emit, load;

   assign adv       = !out_valid_ff || !rsp_stall;
   assign have      = (rem_ff != '0);
   assign emit      = have && adv;
   assign pick      = rem_ff & (~rem_ff + 1'b1);
   assign rem_after = rem_ff & ~pick;
   assign load      = q_valid && (!have || (emit && (rem_after == '0)));
   assign q_pop     = load;
   assign toks      = slot_tokens(digits_ff);

   always_comb begin
      tok_sel = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (pick[i]) begin
            tok_sel = tok_sel | toks[i];
         end
      end
   end

   always_comb begin
      digits_in    = digits_ff;
      rem_in       = rem_ff;
      out_valid_in = out_valid_ff;
      tok_in       = tok_ff;
      last_in      = last_ff;
      if (emit) begin
         rem_in       = rem_after;
         out_valid_in = 1'b1;
         tok_in       = tok_sel;
         last_in      = (rem_after == '0);
      end else if (adv) begin
         out_valid_in = 1'b0;
      end
      if (load) begin
         digits_in = q_digits;
         rem_in    = slot_mask(q_digits);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         out_valid_ff <= out_valid_in;
      end
      digits_ff <= digits_in;
      tok_ff    <= tok_in;
      last_ff   <= last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_word_token = tok_ff;
   assign rsp_last_word  = last_ff;

endmodule

// ===== verif/binary_to_english_number_words_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_english_number_words_tb
// Self-checking bench for the number-to-words block.
// ----------------------------------------------------------------------------
// Numbers go in on the request channel. An independent spelling routine
// predicts the token sequence each accepted number must produce. Every
// response word is checked against the oldest pending token. A short table
// of hand-picked numbers comes first, then about 360 random numbers in
// three phases: a slow receiver, a slow sender, and a flood in which the
// receiver also stalls for a long stretch so the block backs up.
// ----------------------------------------------------------------------------
module binary_to_english_number_words_tb import bwn_pkg::*;;

   localparam int          MAX_WORDS      = 16;
   localparam int          RANDOM_PER_PH  = 120;
   localparam int          HOLD_CYCLES    = 300;
   localparam int          DRAIN_CYCLES   = 40;
   localparam int          CYCLE_LIMIT    = 400000;
   localparam int unsigned NUM_MAX        = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      PH_SLOW_RX,
      PH_SLOW_TX,
      PH_FLOOD
   } run_phase_type;

   // One predicted response word: the token and whether it ends the reading.
   typedef struct {
      token_type token;
      logic      last_flag;
   } spoken_word_type;

   // Hand-typed readings are listed first word first, packed from the top.
   typedef logic [MAX_WORDS*TOK_W-1:0] typed_words_type;

   typedef struct {
      logic [NUM_W-1:0] number;
      int unsigned      typed_cnt;
      typed_words_type  typed_words;
   } directed_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [NUM_W-1:0] req_number_value = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   token_type        rsp_word_token;
   logic             rsp_last_word;

   spoken_word_type pending_words[$];
   int              mismatch_count = 0;
   int              cycle_count = 0;
   int              send_idle_pct = 9;
   int              recv_idle_pct = 71;
   run_phase_type   run_phase = PH_SLOW_RX;
   int              hold_left = 0;
   bit              hold_done = 1'b0;

   // Rows with a nonzero count carry their expected reading; the others are
   // spelled by the prediction routine below.
   directed_row_type directed_rows [24] = '{
      '{31'd0,          1, {TOK_ZERO, 75'd0}},
      '{31'd1,          1, {5'd1, 75'd0}},
      '{31'd9,          0, '0},
      '{31'd10,         0, '0},
      '{31'd11,         0, '0},
      '{31'd15,         0, '0},
      '{31'd19,         0, '0},
      '{31'd20,         0, '0},
      '{31'd21,         0, '0},
      '{31'd99,         0, '0},
      '{31'd100,        0, '0},
      '{31'd101,        0, '0},
      '{31'd110,        0, '0},
      '{31'd999,        0, '0},
      '{31'd1000,       0, '0},
      '{31'd1001,       0, '0},
      '{31'd1000010,    0, '0},
      '{31'd12345,      0, '0},
      '{31'd1000000,    0, '0},
      '{31'd700000000,  0, '0},
      '{31'd1000000000, 2, {5'd1, TOK_BILLION, 70'd0}},
      '{31'd2000000000, 0, '0},
      '{31'd1777777777, 0, '0},
      '{31'd2147483647, 16, {5'd2, TOK_BILLION,
                             5'd1, TOK_HUNDRED, TOK_TENS_OFS + 5'd4, 5'd7, TOK_MILLION,
                             5'd4, TOK_HUNDRED, TOK_TENS_OFS + 5'd8, 5'd3, TOK_THOUSAND,
                             5'd6, TOK_HUNDRED, TOK_TENS_OFS + 5'd4, 5'd7}}
   };

   binary_to_english_number_words u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_number_value (req_number_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_token   (rsp_word_token),
      .rsp_last_word    (rsp_last_word)
   );

   // 10 ns clock; the first rising edge falls at 5 ns.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog. A correct run ends far below this count, even with every
   // number at sixteen words and the receiver stalling most cycles.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[binary_to_english_number_words] ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   function automatic void push_word(input token_type tok);
      spoken_word_type w;
      w.token     = tok;
      w.last_flag = 1'b0;
      pending_words.push_back(w);
   endfunction

   // Spells one group of three digits. An all-zero group says nothing, and
   // the caller then leaves out its scale word as well.
   function automatic bit spell_group(input int unsigned grp);
      int unsigned hun;
      int unsigned ten;
      int unsigned one;
      hun = grp / 100;
      ten = (grp / 10) % 10;
      one = grp % 10;
      if (grp == 0)
         return 1'b0;
      if (hun != 0) begin
         push_word(token_type'(hun));
         push_word(TOK_HUNDRED);
      end
      // The teens are single words, so the ones digit is folded in.
      if (ten == 1) begin
         push_word(TOK_TEN + token_type'(one));
      end else begin
         if (ten >= 2)
            push_word(TOK_TENS_OFS + token_type'(ten));
         if (one != 0)
            push_word(token_type'(one));
      end
      return 1'b1;
   endfunction

   // Appends the full reading of a number to the pending words and flags
   // its final token.
   function automatic void spell_number(input logic [NUM_W-1:0] num);
      int unsigned n;
      int unsigned billions;
      int unsigned rest;
      n        = num;
      billions = n / 1000000000;
      rest     = n % 1000000000;
      if (n == 0) begin
         push_word(TOK_ZERO);
      end else begin
         // Within 31 bits the billions digit is at most two: one ones word.
         if (billions != 0) begin
            void'(spell_group(billions));
            push_word(TOK_BILLION);
         end
         if (spell_group(rest / 1000000))
            push_word(TOK_MILLION);
         if (spell_group((rest / 1000) % 1000))
            push_word(TOK_THOUSAND);
         void'(spell_group(rest % 1000));
      end
      pending_words[pending_words.size()-1].last_flag = 1'b1;
   endfunction

   // Random group with a bias toward the shapes that take different paths:
   // empty groups, teens, round tens and plain random values.
   function automatic int unsigned pick_group();
      case ($urandom_range(3))
         0: return 0;
         1: return $urandom_range(9) * 100 + $urandom_range(19, 10);
         2: return $urandom_range(9) * 100 + $urandom_range(9) * 10;
         default: return $urandom_range(999);
      endcase
   endfunction

   function automatic logic [NUM_W-1:0] pick_number();
      longint unsigned composed;
      case ($urandom_range(4))
         0: return NUM_W'($urandom());
         1: return NUM_W'($urandom_range(999));
         2: return NUM_W'($urandom_range(99));
         default: begin
            // Built group by group so that zero groups inside large numbers
            // turn up often.
            composed = longint'($urandom_range(2)) * 1000000000
                     + longint'(pick_group()) * 1000000
                     + longint'(pick_group()) * 1000
                     + longint'(pick_group());
            if (composed > NUM_MAX)
               composed = composed - 1000000000;
            return NUM_W'(composed);
         end
      endcase
   endfunction

   // Offers one number and returns at the falling edge after it is taken.
   // Called at a falling edge. The expected reading is queued at acceptance,
   // well before any of its words can come out.
   task automatic send_number(input logic [NUM_W-1:0] num, input int unsigned typed_cnt,
                              input typed_words_type typed_words);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_number_value <= num;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (typed_cnt == 0) begin
         spell_number(num);
      end else begin
         for (int i = 0; i < typed_cnt; i++)
            push_word(typed_words[(MAX_WORDS-1-i)*TOK_W +: TOK_W]);
         pending_words[pending_words.size()-1].last_flag = 1'b1;
      end
      @(negedge clock);
   endtask

   // Receiver side. Stall is decided at the falling edge. Once, as the flood
   // phase begins, the receiver holds off for a long stretch while the
   // sender keeps offering numbers, so the block fills and stalls its input.
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (!hold_done && run_phase == PH_FLOOD) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Every accepted response word must match the oldest pending token.
   always @(posedge clock) begin
      spoken_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word: token %0d last %0b",
                                      rsp_word_token, rsp_last_word));
         end else begin
            want = pending_words.pop_front();
            if (rsp_word_token !== want.token)
               report_mismatch($sformatf("token %0d, expected %0d",
                                         rsp_word_token, want.token));
            if (rsp_last_word !== want.last_flag)
               report_mismatch($sformatf("last flag %0b, expected %0b on token %0d",
                                         rsp_last_word, want.last_flag, want.token));
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Hand-picked numbers run under the slow receiver.
      foreach (directed_rows[i])
         send_number(directed_rows[i].number, directed_rows[i].typed_cnt,
                     directed_rows[i].typed_words);

      for (int i = 0; i < RANDOM_PER_PH; i++)
         send_number(pick_number(), 0, '0);

      run_phase     = PH_SLOW_TX;
      send_idle_pct = 71;
      recv_idle_pct = 9;
      for (int i = 0; i < RANDOM_PER_PH; i++)
         send_number(pick_number(), 0, '0);

      // No idling on either side, apart from the one long receiver hold.
      run_phase     = PH_FLOOD;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < RANDOM_PER_PH; i++)
         send_number(pick_number(), 0, '0);
      req_valid <= 1'b0;

      // Drain, then give the block time to show any stray extra word.
      while (pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("[binary_to_english_number_words] OK");
      end else begin
         $display("[binary_to_english_number_words] ERROR");
      end
      $finish;
   end

endmodule
